// ===== design/mhc_pkg.sv =====
`default_nettype none

package mhc_pkg;

    // Sub-unit id space and default number of slots.
    localparam int SUB_ID_LIMIT  = 10;
    localparam int SUB_UNITS_DEF = SUB_ID_LIMIT;

    // Result count per command: holds up to 31, above the default slot count (10).
    localparam int CNT_W = 5;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // APB register map.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_SUB_COUNT = 1'b0;

    typedef enum logic [1:0] {
        MODE_MANUAL     = 2'd0,
        MODE_REQ_AUTO   = 2'd1,
        MODE_AUTO       = 2'd2,
        MODE_REQ_MANUAL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_REQ_AUTO     = 2'd0,
        ACT_REPLY_AUTO   = 2'd1,
        ACT_REPLY_MANUAL = 2'd2,
        ACT_REQ_MANUAL   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SLOT_NONE   = 2'd0,
        SLOT_AUTO   = 2'd1,
        SLOT_MANUAL = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        KIND_REQ_AUTO    = 3'd0,
        KIND_REQ_MANUAL  = 3'd1,
        KIND_AUTO_DONE   = 3'd2,
        KIND_MANUAL_DONE = 3'd3,
        KIND_NONE        = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_FAN_AUTO,
        EV_FAN_MANUAL,
        EV_AUTO_DONE,
        EV_MANUAL_DONE
    } event_t;

    // One queued command: back expands it into cnt result beats.
    typedef struct packed {
        kind_t             kind;
        logic [CNT_W-1:0]  cnt;
        mode_t             mode;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/mhc_if.sv =====
`default_nettype none

interface mhc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] sub_id;

    modport source (output valid, output action, output sub_id, input ready);
    modport sink   (input valid, input action, input sub_id, output ready);
endinterface

interface mhc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] target_sub;
    logic [1:0] mode;
    logic       last;

    modport source (output valid, output kind, output target_sub, output mode,
                    output last, input ready);
    modport sink   (input valid, input kind, input target_sub, input mode,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== design/mhc_front.sv =====
`default_nettype none

module mhc_front #(
    parameter int SUB_UNITS = mhc_pkg::SUB_UNITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [mhc_pkg::CNT_W-1:0] active_cnt,
    mhc_in_if.sink                        in_ch,
    input  wire logic                     q_full,
    output logic                          q_push,
    output mhc_pkg::cmd_t                 q_data
);

    localparam int CW = mhc_pkg::CNT_W;

    mhc_pkg::mode_t   mode_reg, mode_next, mode_new;
    mhc_pkg::slot_t   slot_reg  [SUB_UNITS];
    mhc_pkg::slot_t   slot_next [SUB_UNITS];
    mhc_pkg::slot_t   slot_post [SUB_UNITS];
    mhc_pkg::action_t act;
    mhc_pkg::slot_t   reply_val;
    mhc_pkg::event_t  ev;
    logic [SUB_UNITS-1:0] in_use;
    logic is_reply, id_ok, write_en, clear_en, accept;
    logic all_rep, all_auto, all_man;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !q_full;
    assign q_push      = accept;

    // Slot contents as they stand once this beat's reply is written.
    always_comb
    begin
        act       = mhc_pkg::action_t'(in_ch.action);
        is_reply  = (act == mhc_pkg::ACT_REPLY_AUTO) || (act == mhc_pkg::ACT_REPLY_MANUAL);
        id_ok     = {1'b0, in_ch.sub_id} < CW'(SUB_UNITS);
        reply_val = (act == mhc_pkg::ACT_REPLY_AUTO) ? mhc_pkg::SLOT_AUTO
                                                     : mhc_pkg::SLOT_MANUAL;
        write_en  = id_ok &&
                    (((mode_reg == mhc_pkg::MODE_REQ_AUTO) && is_reply) ||
                     ((mode_reg == mhc_pkg::MODE_REQ_MANUAL) &&
                      (act == mhc_pkg::ACT_REPLY_MANUAL)));
        all_rep  = 1'b1;
        all_auto = 1'b1;
        all_man  = 1'b1;
        for (int i = 0; i < SUB_UNITS; i++)
        begin
            in_use[i]    = CW'(i) < active_cnt;
            slot_post[i] = (write_en && (in_ch.sub_id == 4'(i))) ? reply_val : slot_reg[i];
            if (in_use[i])
            begin
                if (slot_post[i] == mhc_pkg::SLOT_NONE)
                    all_rep = 1'b0;
                if (slot_post[i] != mhc_pkg::SLOT_AUTO)
                    all_auto = 1'b0;
                if (slot_post[i] != mhc_pkg::SLOT_MANUAL)
                    all_man = 1'b0;
            end
        end
    end

    // Next mode and event.
    always_comb
    begin
        mode_new = mode_reg;
        clear_en = 1'b0;
        ev       = mhc_pkg::EV_NONE;
        case (mode_reg)
            mhc_pkg::MODE_MANUAL:
            begin
                if (act == mhc_pkg::ACT_REQ_AUTO)
                begin
                    ev       = mhc_pkg::EV_FAN_AUTO;
                    clear_en = 1'b1;
                    mode_new = mhc_pkg::MODE_REQ_AUTO;
                end
            end
            mhc_pkg::MODE_REQ_AUTO:
            begin
                if (write_en && all_rep)
                begin
                    clear_en = 1'b1;
                    if (all_auto)
                    begin
                        ev       = mhc_pkg::EV_AUTO_DONE;
                        mode_new = mhc_pkg::MODE_AUTO;
                    end
                    else
                    begin
                        // fallback: someone refused automatic
                        ev       = mhc_pkg::EV_FAN_MANUAL;
                        mode_new = mhc_pkg::MODE_MANUAL;
                    end
                end
            end
            mhc_pkg::MODE_AUTO:
            begin
                if (act == mhc_pkg::ACT_REQ_MANUAL)
                begin
                    ev       = mhc_pkg::EV_FAN_MANUAL;
                    clear_en = 1'b1;
                    mode_new = mhc_pkg::MODE_REQ_MANUAL;
                end
            end
            mhc_pkg::MODE_REQ_MANUAL:
            begin
                if (write_en && all_man)
                begin
                    ev       = mhc_pkg::EV_MANUAL_DONE;
                    clear_en = 1'b1;
                    mode_new = mhc_pkg::MODE_MANUAL;
                end
            end
            default:
            begin
                mode_new = mode_reg;
            end
        endcase

        mode_next = accept ? mode_new : mode_reg;
        for (int i = 0; i < SUB_UNITS; i++)
        begin
            if (!accept)
                slot_next[i] = slot_reg[i];
            else if (clear_en && in_use[i])
                slot_next[i] = mhc_pkg::SLOT_NONE;
            else
                slot_next[i] = slot_post[i];
        end
    end

    // Command for the back end.
    always_comb
    begin
        q_data.mode = mode_new;
        q_data.kind = mhc_pkg::KIND_NONE;
        q_data.cnt  = CW'(1);
        case (ev)
            mhc_pkg::EV_FAN_AUTO:
            begin
                if (active_cnt != '0)
                begin
                    q_data.kind = mhc_pkg::KIND_REQ_AUTO;
                    q_data.cnt  = active_cnt;
                end
            end
            mhc_pkg::EV_FAN_MANUAL:
            begin
                if (active_cnt != '0)
                begin
                    q_data.kind = mhc_pkg::KIND_REQ_MANUAL;
                    q_data.cnt  = active_cnt;
                end
            end
            mhc_pkg::EV_AUTO_DONE:   q_data.kind = mhc_pkg::KIND_AUTO_DONE;
            mhc_pkg::EV_MANUAL_DONE: q_data.kind = mhc_pkg::KIND_MANUAL_DONE;
            default:                 q_data.kind = mhc_pkg::KIND_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mhc_pkg::MODE_MANUAL;
            for (int i = 0; i < SUB_UNITS; i++)
                slot_reg[i] <= mhc_pkg::SLOT_NONE;
        end
        else
        begin
            mode_reg <= mode_next;
            for (int i = 0; i < SUB_UNITS; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== design/mhc_queue.sv =====
`default_nettype none

module mhc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mhc_pkg::cmd_t din,
    output logic               full,
    input  wire logic          pop,
    output mhc_pkg::cmd_t      dout,
    output logic               not_empty
);

    // depth must be a power of two so the pointers wrap by themselves
    localparam int DEPTH = mhc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    mhc_pkg::cmd_t   q_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

// ===== design/mhc_back.sv =====
`default_nettype none

module mhc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire mhc_pkg::cmd_t q_data,
    output logic               q_pop,
    mhc_out_if.source          res_ch
);

    localparam int CW = mhc_pkg::CNT_W;

    mhc_pkg::cmd_t   cmd_reg, cmd_next;
    logic            busy_reg, busy_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            ov_reg, ov_next;
    mhc_pkg::kind_t  kind_reg, kind_next;
    logic [3:0]      tgt_reg, tgt_next;
    mhc_pkg::mode_t  mode_reg, mode_next;
    logic            last_reg, last_next;
    logic            load_out, is_last, is_fan;

    assign res_ch.valid      = ov_reg;
    assign res_ch.kind       = kind_reg;
    assign res_ch.target_sub = tgt_reg;
    assign res_ch.mode       = mode_reg;
    assign res_ch.last       = last_reg;

    assign q_pop = !busy_reg && q_valid;

    always_comb
    begin
        load_out  = busy_reg && (!ov_reg || res_ch.ready);
        is_last   = (idx_reg == cmd_reg.cnt - CW'(1));
        is_fan    = (cmd_reg.kind == mhc_pkg::KIND_REQ_AUTO) ||
                    (cmd_reg.kind == mhc_pkg::KIND_REQ_MANUAL);
        cmd_next  = cmd_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg;
        kind_next = kind_reg;
        tgt_next  = tgt_reg;
        mode_next = mode_reg;
        last_next = last_reg;

        if (q_pop)
        begin
            cmd_next  = q_data;
            busy_next = 1'b1;
            idx_next  = '0;
        end

        if (load_out)
        begin
            ov_next   = 1'b1;
            kind_next = cmd_reg.kind;
            tgt_next  = is_fan ? idx_reg[3:0] : 4'd0;
            mode_next = cmd_reg.mode;
            last_next = is_last;
            idx_next  = idx_reg + CW'(1);
            if (is_last)
                busy_next = 1'b0;
        end
        else if (res_ch.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        kind_reg <= kind_next;
        tgt_reg  <= tgt_next;
        mode_reg <= mode_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ===== design/mode_handover_coordinator.sv =====
// An accepted input beat is written into the command queue, then loaded into the back end's
//   command register, then into the result register that drives the first result beat.
// The back end takes a new command only once the last beat of the previous one is loaded.
// Front accepts while the 2-entry command queue has room.
// Reset (rst_n, async, active low): mode manual, all reply slots empty,
//   sub_count 0, queue and output register empty.
`default_nettype none

module mode_handover_coordinator #(
    parameter int SUB_UNITS = mhc_pkg::SUB_UNITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mhc_in_if.sink                           in_ch,
    mhc_out_if.source                        res_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mhc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mhc_pkg::DATA_W-1:0]  pwdata,
    output logic      [mhc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int CW = mhc_pkg::CNT_W;
    localparam int AW = mhc_pkg::ADDR_W;
    localparam int DW = mhc_pkg::DATA_W;

    // ---------------------------------------------------------------
    // APB register: sub_count at byte offset 0. Zero-wait, so pready
    // is tied high. Offsets past the map read as zero, writes dropped.
    // ---------------------------------------------------------------
    logic [3:0]    sub_count_reg, sub_count_next;
    logic          reg_hit;
    logic [CW-1:0] active_cnt;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[AW-1:2] == mhc_pkg::REG_SUB_COUNT);
    assign prdata  = reg_hit ? DW'(sub_count_reg) : '0;

    always_comb
    begin
        sub_count_next = sub_count_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            sub_count_next = pwdata[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_count_reg <= '0;
        else
            sub_count_reg <= sub_count_next;
    end

    // Active sub-units: sub_count saturated at the slot count.
    assign active_cnt = ({1'b0, sub_count_reg} > CW'(SUB_UNITS)) ? CW'(SUB_UNITS)
                                                                 : {1'b0, sub_count_reg};

    // ---------------------------------------------------------------
    // Front: takes the event beat, updates mode and reply slots in the
    // same cycle, and queues one command describing the results.
    // ---------------------------------------------------------------
    logic          q_push, q_full, q_pop, q_nempty;
    mhc_pkg::cmd_t q_din, q_dout;

    mhc_front #(
        .SUB_UNITS (SUB_UNITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .active_cnt (active_cnt),
        .in_ch      (in_ch),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_din)
    );

    // Short command queue so the front keeps taking events while the
    // back end is still fanning out requests.
    mhc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_nempty)
    );

    // ---------------------------------------------------------------
    // Back: expands each command into result beats, one per cycle while
    // res_ch is ready, through a registered output stage; last flags the final beat.
    // ---------------------------------------------------------------
    mhc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_nempty),
        .q_data  (q_dout),
        .q_pop   (q_pop),
        .res_ch  (res_ch)
    );

endmodule

`default_nettype wire

// ===== design/mhc_checker.sv =====
`default_nettype none

module mhc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [2:0] res_kind,
    input wire logic [3:0] res_target,
    input wire logic [1:0] res_mode,
    input wire logic       res_last
);

    // stalled result beat stays up
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    // stalled result beat keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_kind) && $stable(res_target)
                                    && $stable(res_mode) && $stable(res_last))
        else $error("result payload changed while stalled");

    // single-beat kinds always close their input's result group
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == mhc_pkg::KIND_NONE ||
                      res_kind == mhc_pkg::KIND_AUTO_DONE ||
                      res_kind == mhc_pkg::KIND_MANUAL_DONE) |-> res_last)
        else $error("non-request result without last");

    // automatic completion results report the finished mode
    a_done_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == mhc_pkg::KIND_AUTO_DONE) |-> res_mode == mhc_pkg::MODE_AUTO)
        else $error("automatic done with wrong mode");

    // only requests address a sub-unit
    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !(res_kind == mhc_pkg::KIND_REQ_AUTO ||
                       res_kind == mhc_pkg::KIND_REQ_MANUAL) |-> res_target == 4'd0)
        else $error("non-request result with nonzero target");

endmodule

bind mode_handover_coordinator mhc_checker u_mhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .res_kind   (res_ch.kind),
    .res_target (res_ch.target_sub),
    .res_mode   (res_ch.mode),
    .res_last   (res_ch.last)
);

`default_nettype wire

// ===== tb/sv/mode_handover_coordinator_test.sv =====
`timescale 1ns / 1ps

// Event stream in, result beats out, sub_count over APB.
// A local model of the handover state machine predicts every beat at the
// moment its input beat is accepted; the checker pops them in order.
module mode_handover_coordinator_test;

    localparam int NUM_SUBS   = mhc_pkg::SUB_UNITS_DEF;
    localparam int MAX_SHOWN  = 10;
    localparam int PHASE_LEN  = 30;     // useful events per random phase

    typedef struct {
        mhc_pkg::kind_t kind;
        logic [3:0]     target;
        mhc_pkg::mode_t mode;
        logic           last;
    } handover_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [mhc_pkg::ADDR_W-1:0] paddr;
    logic [mhc_pkg::DATA_W-1:0] pwdata;
    logic [mhc_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    mhc_in_if  in_ch ();
    mhc_out_if res_ch ();

    mode_handover_coordinator #(.SUB_UNITS(NUM_SUBS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model of the coordinator: mode, reply slots and the sub_count register.
    mhc_pkg::mode_t model_mode;
    mhc_pkg::slot_t model_slots [NUM_SUBS];
    logic [3:0]     model_sub_count;
    handover_beat_t awaited_beats [$];

    int mismatches = 0;
    bit idle_on    = 1'b1;  // random gaps/stalls enabled on both sides
    int hold_left  = 0;     // long receiver hold-off, cycles still to go
    int stall_left = 0;     // short receiver stall burst

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    // Units taking part: register value saturated at the slot count.
    function automatic int active_units();
        return (model_sub_count > NUM_SUBS) ? NUM_SUBS : int'(model_sub_count);
    endfunction

    function automatic int count_slots(int n, mhc_pkg::slot_t want);
        int hits;
        hits = 0;
        for (int i = 0; i < n; i++)
            if (model_slots[i] == want)
                hits++;
        return hits;
    endfunction

    // Only the active slots are wiped; slots above keep stale replies.
    function automatic void clear_active_slots(int n);
        for (int i = 0; i < n; i++)
            model_slots[i] = mhc_pkg::SLOT_NONE;
    endfunction

    // Advance the model by one event and queue the beats it must produce.
    task automatic predict_handover(mhc_pkg::action_t act, logic [3:0] id);
        int             n;
        bit             is_reply;
        bit             fan;
        mhc_pkg::kind_t fan_kind;
        mhc_pkg::kind_t single;
        n        = active_units();
        is_reply = (act == mhc_pkg::ACT_REPLY_AUTO) || (act == mhc_pkg::ACT_REPLY_MANUAL);
        fan      = 1'b0;
        fan_kind = mhc_pkg::KIND_NONE;
        single   = mhc_pkg::KIND_NONE;
        // replies from ids past the slot array are dropped outright
        if (!(is_reply && id >= NUM_SUBS))
        begin
            case (model_mode)
                mhc_pkg::MODE_MANUAL:
                    if (act == mhc_pkg::ACT_REQ_AUTO)
                    begin
                        fan        = 1'b1;
                        fan_kind   = mhc_pkg::KIND_REQ_AUTO;
                        clear_active_slots(n);
                        model_mode = mhc_pkg::MODE_REQ_AUTO;
                    end
                mhc_pkg::MODE_REQ_AUTO:
                    if (is_reply)
                    begin
                        model_slots[id] = (act == mhc_pkg::ACT_REPLY_AUTO) ? mhc_pkg::SLOT_AUTO
                                                                          : mhc_pkg::SLOT_MANUAL;
                        if (count_slots(n, mhc_pkg::SLOT_NONE) == 0)
                        begin
                            if (count_slots(n, mhc_pkg::SLOT_AUTO) == n)
                            begin
                                single     = mhc_pkg::KIND_AUTO_DONE;
                                model_mode = mhc_pkg::MODE_AUTO;
                            end
                            else
                            begin
                                // somebody refused: back out to manual
                                fan        = 1'b1;
                                fan_kind   = mhc_pkg::KIND_REQ_MANUAL;
                                model_mode = mhc_pkg::MODE_MANUAL;
                            end
                            clear_active_slots(n);
                        end
                    end
                mhc_pkg::MODE_AUTO:
                    if (act == mhc_pkg::ACT_REQ_MANUAL)
                    begin
                        fan        = 1'b1;
                        fan_kind   = mhc_pkg::KIND_REQ_MANUAL;
                        clear_active_slots(n);
                        model_mode = mhc_pkg::MODE_REQ_MANUAL;
                    end
                default:
                    // requesting manual: automatic replies do nothing
                    if (act == mhc_pkg::ACT_REPLY_MANUAL)
                    begin
                        model_slots[id] = mhc_pkg::SLOT_MANUAL;
                        if (count_slots(n, mhc_pkg::SLOT_MANUAL) == n)
                        begin
                            clear_active_slots(n);
                            single     = mhc_pkg::KIND_MANUAL_DONE;
                            model_mode = mhc_pkg::MODE_MANUAL;
                        end
                    end
            endcase
        end
        // a fan-out to zero units leaves only the kind-none beat
        if (fan && n > 0)
        begin
            for (int i = 0; i < n; i++)
                awaited_beats.push_back('{fan_kind, 4'(i), model_mode, i == n - 1});
        end
        else
            awaited_beats.push_back('{single, 4'd0, model_mode, 1'b1});
    endtask

    // Hold valid with the event until the block takes it. valid is left
    // high so back-to-back events never drop it within one step.
    task automatic offer_event(mhc_pkg::action_t act, logic [3:0] id);
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.sub_id <= id;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_handover(act, id);
    endtask

    // Drop valid, let every predicted beat arrive, then let the channels sit quiet.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of sub_count followed by a read-back check.
    task automatic write_sub_count(logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mhc_pkg::REG_SUB_COUNT, 2'b00};
        pwdata  <= mhc_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model_sub_count = value;
        // psel stays up straight into the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== mhc_pkg::DATA_W'(value))
            flag_mismatch($sformatf("sub_count read exp=%0d got=%0h", value, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random event. Mostly the next step of a well-formed handover
    // (useful=1); otherwise a fully random event.
    task automatic random_item(output bit useful);
        int               n;
        int               open_ids [$];
        mhc_pkg::action_t act;
        logic [3:0]       id;
        if (idle_on && $urandom_range(0, 99) < 20)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        n = active_units();
        for (int i = 0; i < n; i++)
            if (model_slots[i] == mhc_pkg::SLOT_NONE)
                open_ids.push_back(i);
        // pick a unit that still owes a reply, now and then any unit
        if (open_ids.size() > 0 && $urandom_range(0, 9) != 0)
            id = 4'(open_ids[$urandom_range(0, open_ids.size() - 1)]);
        else
            id = 4'($urandom_range(0, NUM_SUBS - 1));
        useful = ($urandom_range(0, 99) < 85);
        if (!useful)
        begin
            act = mhc_pkg::action_t'($urandom_range(0, 3));
            id  = 4'($urandom_range(0, 15));
        end
        else
        begin
            case (model_mode)
                mhc_pkg::MODE_MANUAL:
                begin
                    act = mhc_pkg::ACT_REQ_AUTO;
                    id  = 4'($urandom_range(0, 15));
                end
                mhc_pkg::MODE_AUTO:
                begin
                    act = mhc_pkg::ACT_REQ_MANUAL;
                    id  = 4'($urandom_range(0, 15));
                end
                mhc_pkg::MODE_REQ_AUTO:
                    act = ($urandom_range(0, 99) < 92) ? mhc_pkg::ACT_REPLY_AUTO
                                                       : mhc_pkg::ACT_REPLY_MANUAL;
                default:
                    act = mhc_pkg::ACT_REPLY_MANUAL;
            endcase
        end
        offer_event(act, id);
    endtask

    task automatic run_random(int count);
        int done;
        bit useful;
        done = 0;
        while (done < count)
        begin
            random_item(useful);
            if (useful)
                done++;
        end
    endtask

    // No units attached: every request completes on the first in-range reply that the mode accepts.
    // Also covers ignored events in each mode and out-of-range ids.
    task automatic test_zero_units();
        offer_event(mhc_pkg::ACT_REQ_MANUAL,   4'd0);   // ignored in manual
        offer_event(mhc_pkg::ACT_REPLY_AUTO,   4'd4);   // ignored in manual
        offer_event(mhc_pkg::ACT_REQ_AUTO,     4'd15);  // nothing to fan out
        offer_event(mhc_pkg::ACT_REPLY_AUTO,   4'd12);  // id past the slots
        offer_event(mhc_pkg::ACT_REPLY_MANUAL, 4'd15);  // id past the slots
        offer_event(mhc_pkg::ACT_REPLY_AUTO,   4'd3);   // completes at once
        offer_event(mhc_pkg::ACT_REQ_AUTO,     4'd0);   // ignored in automatic
        offer_event(mhc_pkg::ACT_REPLY_MANUAL, 4'd9);   // ignored in automatic
        offer_event(mhc_pkg::ACT_REQ_MANUAL,   4'd0);
        offer_event(mhc_pkg::ACT_REPLY_AUTO,   4'd0);   // ignored while requesting manual
        offer_event(mhc_pkg::ACT_REPLY_MANUAL, 4'd9);   // manual done
        wait_quiet();
    endtask

    // Two units, one refuses: fallback fans manual requests out again.
    // A reply from an inactive unit is stored but not counted.
    task automatic test_partial_fallback();
        write_sub_count(4'd2);
        offer_event(mhc_pkg::ACT_REQ_AUTO,     4'd10);
        offer_event(mhc_pkg::ACT_REPLY_MANUAL, 4'd5);
        offer_event(mhc_pkg::ACT_REPLY_AUTO,   4'd0);
        offer_event(mhc_pkg::ACT_REPLY_MANUAL, 4'd1);
        wait_quiet();
    endtask

    // Register above the slot count: fan-out saturates at ten beats.
    task automatic test_saturated_fanout();
        write_sub_count(4'd15);
        offer_event(mhc_pkg::ACT_REQ_AUTO,   4'd0);
        offer_event(mhc_pkg::ACT_REQ_MANUAL, 4'd7);     // unexpected while requesting auto
        offer_event(mhc_pkg::ACT_REPLY_AUTO, 4'd9);
        wait_quiet();
    endtask

    // Random handovers over a series of unit counts, both extremes included.
    task automatic test_random_phases();
        logic [3:0] counts [7];
        counts = '{4'd1, 4'd10, 4'd3, 4'd0, 4'd15, 4'd7, 4'($urandom_range(0, 15))};
        foreach (counts[i])
        begin
            write_sub_count(counts[i]);
            run_random(PHASE_LEN);
            wait_quiet();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing events,
    // among them ten-beat fan-outs, so the command queue fills and input stalls.
    task automatic test_backpressure();
        write_sub_count(4'd10);
        idle_on   = 1'b0;
        hold_left = 150;
        run_random(20);
        idle_on   = 1'b1;
        wait_quiet();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_sub_count(4'($urandom_range(1, 10)));
        run_random(24);
        wait_quiet();
    endtask

    // Result side ready: long hold-off first, then random short stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 7)
                stall_left = $urandom_range(1, 12);
        end
    end

    // Every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin : check_beats
        handover_beat_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_beats.size() == 0)
                flag_mismatch($sformatf("unexpected beat kind=%0d sub=%0d mode=%0d last=%0d",
                    res_ch.kind, res_ch.target_sub, res_ch.mode, res_ch.last));
            else
            begin
                want = awaited_beats.pop_front();
                if (res_ch.kind !== want.kind || res_ch.target_sub !== want.target ||
                    res_ch.mode !== want.mode || res_ch.last !== want.last)
                    flag_mismatch($sformatf(
                        "exp kind=%0d sub=%0d mode=%0d last=%0d got kind=%0d sub=%0d mode=%0d last=%0d",
                        want.kind, want.target, want.mode, want.last,
                        res_ch.kind, res_ch.target_sub, res_ch.mode, res_ch.last));
            end
        end
    end

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.action = mhc_pkg::ACT_REQ_AUTO;
        in_ch.sub_id = 4'd0;
        res_ch.ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        model_mode      = mhc_pkg::MODE_MANUAL;
        model_sub_count = 4'd0;
        foreach (model_slots[i])
            model_slots[i] = mhc_pkg::SLOT_NONE;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_units();
        test_partial_fallback();
        test_saturated_fanout();
        test_random_phases();
        test_backpressure();
        test_steady_stream();

        // all beats are in; give the block time to show any stray one
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
